// File: src/ctes_pkg.sv
`timescale 1ns / 1ps

package ctes_pkg;

  localparam int YearW  = 12;  // folded year, 1889..2933
  localparam int DayW   = 22;  // signed day number from 1970-01-01
  localparam int TodW   = 29;  // signed seconds from hour, minute, second
  localparam int EpochW = 38;

  localparam logic [11:0]        YearBase  = 12'd1889;  // 1900 less the eleven-year bias
  localparam logic [8:0]         MonBias   = 9'd4;      // with the sign flip: month + 132
  localparam logic [9:0]         Recip12   = 10'd683;   // x * 683 >> 13 == x / 12, x < 260
  localparam logic [10:0]        Recip25   = 11'd1311;  // x * 1311 >> 15 == x / 25, x < 734
  localparam logic [8:0]         YearDays  = 9'd365;
  localparam logic [21:0]        EpochDays = 22'd719163; // days before 1970 plus the one-based day
  localparam logic signed [12:0] HourSecs  = 13'sd3600;
  localparam logic signed [7:0]  MinSecs   = 8'sd60;
  localparam logic signed [17:0] DaySecs   = 18'sd86400;

  typedef struct packed {
    logic [YearW-1:0]       year;
    logic [3:0]             mon;
    logic signed [15:0]     mday;
    logic signed [TodW-1:0] tod;
  } fold_t;

  typedef struct packed {
    logic signed [DayW-1:0] days;
    logic signed [TodW-1:0] tod;
  } days_t;

  // Days before the first of the month; one more from March on in a leap year.
  function automatic logic [8:0] cum_days(input logic leap, input logic [3:0] mon);
    logic [8:0] base;
    unique case (mon)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    return base + {8'd0, leap && (mon >= 4'd2)};
  endfunction

endpackage

// File: src/ctes_time_if.sv
`timescale 1ns / 1ps

interface ctes_time_if;
  logic               valid;
  logic               ready;
  logic [9:0]         years_since_1900;
  logic signed [7:0]  month_index;
  logic signed [15:0] day_of_month;
  logic signed [15:0] hour_value;
  logic signed [15:0] minute_value;
  logic signed [15:0] second_value;

  modport source (output valid, years_since_1900, month_index, day_of_month, hour_value,
                  minute_value, second_value, input ready);
  modport sink (input valid, years_since_1900, month_index, day_of_month, hour_value,
                minute_value, second_value, output ready);
endinterface

// File: src/ctes_epoch_if.sv
`timescale 1ns / 1ps

interface ctes_epoch_if;
  logic               valid;
  logic               ready;
  logic signed [37:0] epoch_seconds;

  modport source (output valid, epoch_seconds, input ready);
  modport sink (input valid, epoch_seconds, output ready);
endinterface

// File: src/ctes_fold.sv
`timescale 1ns / 1ps

// Stages 1-2: month folded into the year by floor division by 12; time of day in seconds.
module ctes_fold (
  input  logic             clk,
  input  logic             rst,
  ctes_time_if.sink        time_in,
  output logic             dn_valid,
  input  logic             dn_ready,
  output ctes_pkg::fold_t  dn_data
);
  import ctes_pkg::*;

  logic                   v1;
  logic                   rdy1;
  logic                   rdy2;
  logic [8:0]             mx;
  logic [18:0]            mprod;
  logic [9:0]             years;
  logic signed [15:0]     mday;
  logic signed [27:0]     hour_s;
  logic signed [21:0]     min_s;
  logic signed [15:0]     sec;
  logic [4:0]             q;
  logic [8:0]             rem;
  fold_t                  fold_next;

  assign rdy2 = !dn_valid || dn_ready;
  assign rdy1 = !v1 || rdy2;
  assign time_in.ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      dn_valid <= 1'b0;
    end else begin
      if (rdy1) v1 <= time_in.valid;
      if (rdy2) dn_valid <= v1;
    end
  end

  // month + 132 lies in 4..259, so the quotient is floor(month / 12) + 11
  always_ff @(posedge clk) begin
    if (rdy1 && time_in.valid) begin
      mx     <= {1'b0, ~time_in.month_index[7], time_in.month_index[6:0]} + MonBias;
      mprod  <= 19'({1'b0, ~time_in.month_index[7], time_in.month_index[6:0]} + MonBias)
                * 19'(Recip12);
      years  <= time_in.years_since_1900;
      mday   <= time_in.day_of_month;
      hour_s <= 28'(time_in.hour_value) * 28'(HourSecs);
      min_s  <= 22'(time_in.minute_value) * 22'(MinSecs);
      sec    <= time_in.second_value;
    end
  end

  always_comb begin
    q              = mprod[17:13];
    rem            = mx - 9'({4'd0, q} * 9'd12);
    fold_next.year = YearBase + 12'(years) + 12'(q);
    fold_next.mon  = rem[3:0];
    fold_next.mday = mday;
    fold_next.tod  = TodW'(hour_s) + TodW'(min_s) + TodW'(sec);
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1) dn_data <= fold_next;
  end

endmodule

// File: src/ctes_days.sv
`timescale 1ns / 1ps

// Stages 3-4: leap rule and day number relative to 1970-01-01.
module ctes_days (
  input  logic             clk,
  input  logic             rst,
  input  logic             up_valid,
  output logic             up_ready,
  input  ctes_pkg::fold_t  up_data,
  output logic             dn_valid,
  input  logic             dn_ready,
  output ctes_pkg::days_t  dn_data
);
  import ctes_pkg::*;

  logic                   v1;
  logic                   rdy1;
  logic                   rdy2;
  logic [20:0]            p365;
  logic [9:0]             p4;
  logic [19:0]            p100prod;
  logic [9:0]             y4;
  logic [19:0]            y100prod;
  logic                   low_zero;
  logic [3:0]             mon;
  logic signed [15:0]     mday;
  logic signed [TodW-1:0] tod;
  logic [4:0]             p100;
  logic [4:0]             y100;
  logic                   cent;
  logic                   leap;
  logic [DayW-1:0]        pos;
  logic [DayW-1:0]        neg;
  days_t                  days_next;

  assign rdy2 = !dn_valid || dn_ready;
  assign rdy1 = !v1 || rdy2;
  assign up_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      dn_valid <= 1'b0;
    end else begin
      if (rdy1) v1 <= up_valid;
      if (rdy2) dn_valid <= v1;
    end
  end

  // p = year - 1; p/100 and year/100 both taken as (x/4)/25
  always_ff @(posedge clk) begin
    if (rdy1 && up_valid) begin
      p365     <= 21'(up_data.year - 12'd1) * 21'(YearDays);
      p4       <= 10'((up_data.year - 12'd1) >> 2);
      p100prod <= 20'(10'((up_data.year - 12'd1) >> 2)) * 20'(Recip25);
      y4       <= up_data.year[11:2];
      y100prod <= 20'(up_data.year[11:2]) * 20'(Recip25);
      low_zero <= (up_data.year[1:0] == 2'd0);
      mon      <= up_data.mon;
      mday     <= up_data.mday;
      tod      <= up_data.tod;
    end
  end

  always_comb begin
    p100 = p100prod[19:15];
    y100 = y100prod[19:15];
    cent = (y4 == 10'({5'd0, y100} * 10'd25));
    leap = low_zero && (!cent || (y100[1:0] == 2'd0));
    pos  = 22'(p365) + 22'(p4) + 22'(p100[4:2]) + 22'(cum_days(leap, mon));
    neg  = 22'(p100) + EpochDays;
    days_next.days = $signed(pos) - $signed(neg) + DayW'(mday);
    days_next.tod  = tod;
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1) dn_data <= days_next;
  end

endmodule

// File: src/ctes_scale.sv
`timescale 1ns / 1ps

// Stages 5-6: days to seconds, then the time of day added; stage 6 is the output register.
module ctes_scale (
  input  logic             clk,
  input  logic             rst,
  input  logic             up_valid,
  output logic             up_ready,
  input  ctes_pkg::days_t  up_data,
  ctes_epoch_if.source     epoch_out
);
  import ctes_pkg::*;

  logic                     v1;
  logic                     rdy1;
  logic                     rdy2;
  logic signed [EpochW-1:0] day_secs;
  logic signed [TodW-1:0]   tod;

  assign rdy2 = !epoch_out.valid || epoch_out.ready;
  assign rdy1 = !v1 || rdy2;
  assign up_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1              <= 1'b0;
      epoch_out.valid <= 1'b0;
    end else begin
      if (rdy1) v1 <= up_valid;
      if (rdy2) epoch_out.valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && up_valid) begin
      day_secs <= EpochW'(up_data.days) * EpochW'(DaySecs);
      tod      <= up_data.tod;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1) epoch_out.epoch_seconds <= day_secs + EpochW'(tod);
  end

endmodule

// File: src/civil_time_to_epoch_seconds.sv
`timescale 1ns / 1ps

// Broken-down UTC time (years since 1900, month folded into the year, day, hour, minute,
// second added without range checks) to signed seconds since 1970-01-01 00:00:00 UTC.
// Six register stages: month fold, time of day, leap rule, day number, days-to-seconds
// multiply and final add, the last being the output register. One transfer per cycle is
// taken in while the output is not stalled. Each stage holds its own valid bit, so a stall at
// the output only backs up stages that are full; bubbles are squeezed out. No state is kept
// between items.
module civil_time_to_epoch_seconds (
  input  logic          clk,
  input  logic          rst,
  ctes_time_if.sink     time_in,
  ctes_epoch_if.source  epoch_out
);
  import ctes_pkg::*;

  logic  fold_valid;
  logic  fold_ready;
  fold_t fold_data;
  logic  days_valid;
  logic  days_ready;
  days_t days_data;

  ctes_fold u_fold (
    .clk      (clk),
    .rst      (rst),
    .time_in  (time_in),
    .dn_valid (fold_valid),
    .dn_ready (fold_ready),
    .dn_data  (fold_data)
  );

  ctes_days u_days (
    .clk      (clk),
    .rst      (rst),
    .up_valid (fold_valid),
    .up_ready (fold_ready),
    .up_data  (fold_data),
    .dn_valid (days_valid),
    .dn_ready (days_ready),
    .dn_data  (days_data)
  );

  ctes_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (days_valid),
    .up_ready  (days_ready),
    .up_data   (days_data),
    .epoch_out (epoch_out)
  );

  // back-pressure at the input only ever starts from a held result at the output
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !time_in.ready |-> (epoch_out.valid && !epoch_out.ready))
    else $error("input stalled without an output stall");

  a_reset_empty: assert property (@(posedge clk) rst |=> !epoch_out.valid)
    else $error("result presented straight after reset");

  // results stay well within 2^35 seconds either side of the epoch
  a_result_range: assert property (@(posedge clk) disable iff (rst)
    epoch_out.valid |-> (epoch_out.epoch_seconds[37:35] == 3'b000 ||
                         epoch_out.epoch_seconds[37:35] == 3'b111))
    else $error("result outside the reachable range");

endmodule

// File: sim/civil_time_to_epoch_seconds_tb.sv
`timescale 1ns / 1ps

module civil_time_to_epoch_seconds_tb;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 1250;
  localparam int SETTLE_CYCLES = 20;
  localparam int LONG_HOLD    = 150;
  localparam int MAX_REPORTS  = 10;

  typedef logic signed [ctes_pkg::EpochW-1:0] epoch_t;

  typedef struct packed {
    logic [9:0]         yrs;
    logic signed [7:0]  mon;
    logic signed [15:0] mday;
    logic signed [15:0] hour;
    logic signed [15:0] minute;
    logic signed [15:0] sec;
  } civil_time_t;

  // Expected epoch values, oldest first, worked out from each accepted time.
  class epoch_ledger;
    epoch_t expected_q[$];
    int     errors;

    function longint days_to_jan1(longint y);
      longint p;
      p = y - 1;
      return 365 * p + p / 400 - p / 100 + p / 4;
    endfunction

    function longint month_start(longint m);
      case (m)
        0:       return 0;
        1:       return 31;
        2:       return 59;
        3:       return 90;
        4:       return 120;
        5:       return 151;
        6:       return 181;
        7:       return 212;
        8:       return 243;
        9:       return 273;
        10:      return 304;
        default: return 334;
      endcase
    endfunction

    function epoch_t epoch_of(civil_time_t t);
      longint year, mon, carry, mday, hour, minute, sec, leap_adj, days, total;
      bit     leap;
      year   = longint'(t.yrs) + 1900;
      mon    = $signed(t.mon);
      mday   = $signed(t.mday);
      hour   = $signed(t.hour);
      minute = $signed(t.minute);
      sec    = $signed(t.sec);
      // fold the month into 0..11, carrying whole years
      if (mon > 11) begin
        year = year + mon / 12;
        mon  = mon % 12;
      end else if (mon < 0) begin
        carry = (11 - mon) / 12;
        year  = year - carry;
        mon   = mon + 12 * carry;
      end
      leap     = (year % 400 == 0) || ((year % 100 != 0) && (year % 4 == 0));
      leap_adj = (leap && mon >= 2) ? 1 : 0;
      days  = days_to_jan1(year) - days_to_jan1(1970) + month_start(mon) + leap_adj
              + mday - 1;
      total = days * 86400 + 3600 * hour + 60 * minute + sec;
      return total[ctes_pkg::EpochW-1:0];
    endfunction

    function void note_time(civil_time_t t);
      expected_q.push_back(epoch_of(t));
    endfunction

    function void check_epoch(epoch_t got);
      epoch_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected result transfer: got %0d", got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("epoch_seconds mismatch: expected %0d, got %0d", want, got);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   long_hold_req;
  int   cycle_count;

  epoch_ledger ledger = new();

  ctes_time_if  time_ch ();
  ctes_epoch_if epoch_ch ();

  civil_time_to_epoch_seconds u_dut (
    .clk       (clk),
    .rst       (rst),
    .time_in   (time_ch),
    .epoch_out (epoch_ch)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && epoch_ch.valid === 1'b1 && epoch_ch.ready === 1'b1)
      ledger.check_epoch(epoch_ch.epoch_seconds);
  end

  function automatic civil_time_t make_time(int y, int m, int d, int h, int mi, int s);
    civil_time_t t;
    t.yrs    = y[9:0];
    t.mon    = m[7:0];
    t.mday   = d[15:0];
    t.hour   = h[15:0];
    t.minute = mi[15:0];
    t.sec    = s[15:0];
    return t;
  endfunction

  function automatic civil_time_t random_time();
    civil_time_t t;
    int          r;
    r = $urandom_range(0, 9);
    t.yrs = 10'($urandom_range(0, 1023));
    if (r < 6) begin
      t.mon    = 8'($urandom_range(0, 11));
      t.mday   = 16'($urandom_range(1, 31));
      t.hour   = 16'($urandom_range(0, 23));
      t.minute = 16'($urandom_range(0, 59));
      t.sec    = 16'($urandom_range(0, 60));
    end else if (r < 8) begin
      // a little outside the calendar ranges
      t.mon    = 8'(int'($urandom_range(0, 72)) - 36);
      t.mday   = 16'(int'($urandom_range(0, 120)) - 40);
      t.hour   = 16'(int'($urandom_range(0, 100)) - 50);
      t.minute = 16'(int'($urandom_range(0, 200)) - 100);
      t.sec    = 16'(int'($urandom_range(0, 200)) - 100);
    end else begin
      t.mon    = 8'($urandom);
      t.mday   = 16'($urandom);
      t.hour   = 16'($urandom);
      t.minute = 16'($urandom);
      t.sec    = 16'($urandom);
    end
    return t;
  endfunction

  function automatic int sender_gap(bit no_gaps);
    int r;
    if (no_gaps)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 65)
      return 0;
    else if (r < 92)
      return $urandom_range(1, 3);
    else
      return $urandom_range(8, 40);
  endfunction

  task automatic send_time(input civil_time_t t);
    @(negedge clk);
    time_ch.valid            = 1'b1;
    time_ch.years_since_1900 = t.yrs;
    time_ch.month_index      = t.mon;
    time_ch.day_of_month     = t.mday;
    time_ch.hour_value       = t.hour;
    time_ch.minute_value     = t.minute;
    time_ch.second_value     = t.sec;
    do @(posedge clk); while (time_ch.ready !== 1'b1);
    ledger.note_time(t);
  endtask

  task automatic pause_sender(input int n);
    repeat (n) begin
      @(negedge clk);
      time_ch.valid = 1'b0;
    end
  endtask

  task automatic send_directed(input int y, input int m, input int d, input int h,
                               input int mi, input int s);
    send_time(make_time(y, m, d, h, mi, s));
    pause_sender(sender_gap(1'b0));
  endtask

  task automatic drain_results();
    @(negedge clk);
    time_ch.valid = 1'b0;
    while (ledger.expected_q.size() != 0)
      @(posedge clk);
  endtask

  // Result side: short random stalls, ready bursts, and the odd long hold-off.
  initial begin
    int hold_left;
    int burst_left;
    int r;
    bit hold_taken;
    hold_left      = 0;
    burst_left     = 0;
    hold_taken     = 1'b0;
    epoch_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = LONG_HOLD;
      end
      if (rst) begin
        epoch_ch.ready = 1'b0;
      end else if (hold_left > 0) begin
        epoch_ch.ready = 1'b0;
        hold_left--;
      end else if (burst_left > 0) begin
        epoch_ch.ready = 1'b1;
        burst_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          epoch_ch.ready = 1'b1;
        end else if (r < 85) begin
          epoch_ch.ready = 1'b0;
          hold_left      = $urandom_range(0, 2);
        end else if (r < 96) begin
          epoch_ch.ready = 1'b1;
          burst_left     = $urandom_range(20, 80);
        end else begin
          epoch_ch.ready = 1'b0;
          hold_left      = $urandom_range(8, 40);
        end
      end
    end
  end

  initial begin
    int i;
    rst                      = 1'b1;
    long_hold_req            = 1'b0;
    time_ch.valid            = 1'b0;
    time_ch.years_since_1900 = '0;
    time_ch.month_index      = '0;
    time_ch.day_of_month     = '0;
    time_ch.hour_value       = '0;
    time_ch.minute_value     = '0;
    time_ch.second_value     = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_directed(70, 0, 1, 0, 0, 0);              // the epoch itself
    send_directed(0, 0, 1, 0, 0, 0);
    send_directed(1023, 11, 31, 23, 59, 59);
    send_directed(100, 1, 29, 12, 0, 0);           // leap day, year divisible by 400
    send_directed(100, 2, 1, 0, 0, 0);
    send_directed(200, 2, 1, 0, 0, 0);             // century, not leap
    send_directed(500, 2, 1, 0, 0, 0);
    send_directed(96, 2, 1, 0, 0, 0);
    send_directed(0, 2, 1, 0, 0, 0);
    send_directed(70, 11, 31, 0, 0, 0);
    send_directed(70, 12, 1, 0, 0, 0);             // month carried into next year
    send_directed(70, 127, 1, 0, 0, 0);
    send_directed(70, -1, 1, 0, 0, 0);             // negative month borrows a year
    send_directed(70, -12, 1, 0, 0, 0);
    send_directed(5, -13, 15, -1, -1, -1);
    send_directed(0, -128, 1, 0, 0, 0);
    send_directed(1023, 127, 1, 0, 0, 0);
    send_directed(70, 0, 0, 0, 0, 0);              // day zero: last day of previous month
    send_directed(70, 0, -32768, 0, 0, 0);
    send_directed(70, 0, 32767, 0, 0, 0);
    send_directed(70, 0, 1, -32768, -32768, -32768);
    send_directed(70, 0, 1, 32767, 32767, 32767);
    send_directed(0, -128, -32768, -32768, -32768, -32768);
    send_directed(1023, 127, 32767, 32767, 32767, 32767);
    drain_results();

    // output held off while transfers keep coming, so the pipe backs up
    long_hold_req = 1'b1;
    repeat (40) send_time(random_time());
    drain_results();

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      send_time(random_time());
      pause_sender(sender_gap((i % 250) < 50));
      if (i == RANDOM_ITEMS / 2)
        drain_results();
    end
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (ledger.errors == 0 && ledger.expected_q.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// File: filelist.f
src/ctes_pkg.sv
src/ctes_time_if.sv
src/ctes_epoch_if.sv
src/ctes_fold.sv
src/ctes_days.sv
src/ctes_scale.sv
src/civil_time_to_epoch_seconds.sv
sim/civil_time_to_epoch_seconds_tb.sv
